// File: rtl/grid_line_of_sight_walker_unit_assert.svh
// assertion macros used by the line-of-sight walker checker
`ifndef GRID_LINE_OF_SIGHT_WALKER_UNIT_ASSERT_SVH
`define GRID_LINE_OF_SIGHT_WALKER_UNIT_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define GLOSW_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define GLOSW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/glosw_pkg.sv
// types and constants of the line-of-sight walker
`timescale 1ns / 1ps

package glosw_pkg;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CAST  = 1'b1;

   localparam int QUEUE_DEPTH  = 4;
   localparam int STEP_GUARD   = 1024;
   localparam int STEP_WIDTH   = 11;
   localparam int COORD_WIDTH  = 9;
   localparam int DELTA_WIDTH  = 9;
   localparam int LEN_SQ_WIDTH = 17;
   localparam int REL_WIDTH    = 10;
   localparam int PROD_WIDTH   = 19;
   localparam int ERR_WIDTH    = 20;
   localparam int MAG_WIDTH    = 19;
   localparam int SQ_WIDTH     = 38;
   localparam int CMP_WIDTH    = 40;

   typedef struct packed {
      logic              cmd;
      logic [5:0]        cell_x;
      logic [5:0]        cell_y;
      logic              cell_walkable;
      logic signed [7:0] origin_x;
      logic signed [7:0] origin_y;
      logic signed [7:0] target_x;
      logic signed [7:0] target_y;
   } req_type;

   typedef struct packed {
      logic signed [7:0] seen_x;
      logic signed [7:0] seen_y;
      logic              blocked;
   } rsp_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_CAST  = 1'b1
   } op_type;

   typedef struct packed {
      op_type                        op;
      logic [5:0]                    cell_x;
      logic [5:0]                    cell_y;
      logic                          walkable;
      logic signed [7:0]             origin_x;
      logic signed [7:0]             origin_y;
      logic signed [7:0]             target_x;
      logic signed [7:0]             target_y;
      logic                          step_x_neg;
      logic                          step_y_neg;
      logic signed [DELTA_WIDTH-1:0] delta_x;
      logic signed [DELTA_WIDTH-1:0] delta_y;
      logic [LEN_SQ_WIDTH-1:0]       len_sq;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_LOOK,
      BK_SQUARE,
      BK_DECIDE
   } bk_state_type;

endpackage

// File: rtl/glosw_ram.sv
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps

module glosw_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/glosw_front.sv
// front end: takes request beats, sorts writes from casts, prepares cast geometry
`timescale 1ns / 1ps

module glosw_front #(
   parameter int MAP_SIDE = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  glosw_pkg::req_type     req_item,
   input  logic                   clearing,
   input  glosw_pkg::q_status_type q_status,
   output logic                   push,
   output glosw_pkg::job_type     push_job
);
   import glosw_pkg::*;

   localparam logic [7:0] MapSide8 = 8'(MAP_SIDE);

   logic                          fe_valid_ff, fe_valid_in;
   req_type                       fe_item_ff, fe_item_in;
   logic                          accept;
   logic                          write_in_map;
   logic                          drop;
   logic                          consumed;
   logic signed [DELTA_WIDTH-1:0] delta_x;
   logic signed [DELTA_WIDTH-1:0] delta_y;
   logic signed [17:0]            delta_x_w;
   logic signed [17:0]            delta_y_w;
   logic signed [17:0]            len_sum;

   assign accept       = start && !busy;
   assign write_in_map = ({2'b00, fe_item_ff.cell_x} < MapSide8)
                      && ({2'b00, fe_item_ff.cell_y} < MapSide8);
   // writes off the map are simply swallowed
   assign drop         = (fe_item_ff.cmd == CMD_WRITE) && !write_in_map;
   assign consumed     = fe_valid_ff && (drop || !q_status.full);
   assign push         = fe_valid_ff && !drop && !q_status.full;
   assign busy         = clearing || (fe_valid_ff && !consumed);

   assign fe_valid_in = accept || (fe_valid_ff && !consumed);
   assign fe_item_in  = accept ? req_item : fe_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fe_valid_ff <= 1'b0;
      end else begin
         fe_valid_ff <= fe_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fe_item_ff <= fe_item_in;
   end

   // line geometry
   always_comb begin
      delta_x   = DELTA_WIDTH'(fe_item_ff.target_x) - DELTA_WIDTH'(fe_item_ff.origin_x);
      delta_y   = DELTA_WIDTH'(fe_item_ff.target_y) - DELTA_WIDTH'(fe_item_ff.origin_y);
      delta_x_w = 18'(delta_x);
      delta_y_w = 18'(delta_y);
      len_sum   = delta_x_w * delta_x_w + delta_y_w * delta_y_w;
   end

   always_comb begin
      push_job.op         = (fe_item_ff.cmd == CMD_CAST) ? OP_CAST : OP_WRITE;
      push_job.cell_x     = fe_item_ff.cell_x;
      push_job.cell_y     = fe_item_ff.cell_y;
      push_job.walkable   = fe_item_ff.cell_walkable;
      push_job.origin_x   = fe_item_ff.origin_x;
      push_job.origin_y   = fe_item_ff.origin_y;
      push_job.target_x   = fe_item_ff.target_x;
      push_job.target_y   = fe_item_ff.target_y;
      push_job.step_x_neg = !(fe_item_ff.origin_x < fe_item_ff.target_x);
      push_job.step_y_neg = !(fe_item_ff.origin_y < fe_item_ff.target_y);
      push_job.delta_x    = delta_x;
      push_job.delta_y    = delta_y;
      push_job.len_sq     = len_sum[LEN_SQ_WIDTH-1:0];
   end

endmodule

// File: rtl/glosw_queue.sv
// short job queue between front end and walker
`timescale 1ns / 1ps

module glosw_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  glosw_pkg::job_type      push_job,
   input  logic                    pop,
   output glosw_pkg::job_type      head_job,
   output glosw_pkg::q_status_type status
);
   import glosw_pkg::*;

   localparam int PtrWidth   = $clog2(QUEUE_DEPTH);
   localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrWidth-1:0]   PtrLast   = PtrWidth'(QUEUE_DEPTH - 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(QUEUE_DEPTH);

   job_type               slots_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job     = slots_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CountFull);
   assign status.empty = (count_ff == '0);

endmodule

// File: rtl/glosw_back.sv
// back end: map store, clearing pass and the cell-by-cell walker
`timescale 1ns / 1ps

module glosw_back #(
   parameter int MAP_SIDE = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  glosw_pkg::q_status_type q_status,
   input  glosw_pkg::job_type      head_job,
   output logic                    pop,
   output logic                    clearing,
   output logic                    rsp_valid,
   output glosw_pkg::rsp_type      rsp_item
);
   import glosw_pkg::*;

   localparam int MapDepth      = MAP_SIDE * MAP_SIDE;
   localparam int MapAddrWidth  = $clog2(MapDepth);
   localparam int AddrCalcWidth = MapAddrWidth + 8;
   localparam logic [MapAddrWidth-1:0] MapLastAddr = MapAddrWidth'(MapDepth - 1);
   localparam logic signed [COORD_WIDTH-1:0] MapLimit     = COORD_WIDTH'(MAP_SIDE);
   localparam logic signed [COORD_WIDTH-1:0] CoordOne     = COORD_WIDTH'(1);
   localparam logic signed [COORD_WIDTH-1:0] CoordMinus   = '1;
   localparam logic signed [REL_WIDTH-1:0]   RelOne       = REL_WIDTH'(1);
   localparam logic signed [REL_WIDTH-1:0]   RelMinus     = '1;
   localparam logic [STEP_WIDTH-1:0]         StepGuardVal = STEP_WIDTH'(STEP_GUARD);

   function automatic logic [MapAddrWidth-1:0] map_addr(input logic [7:0] col,
                                                        input logic [7:0] row);
      logic [AddrCalcWidth-1:0] linear;
      linear = AddrCalcWidth'(row) * AddrCalcWidth'(MAP_SIDE) + AddrCalcWidth'(col);
      return linear[MapAddrWidth-1:0];
   endfunction

   bk_state_type                  state_ff, state_in;
   logic [MapAddrWidth-1:0]       clr_addr_ff, clr_addr_in;
   job_type                       job_ff, job_in;
   logic signed [COORD_WIDTH-1:0] walk_x_ff, walk_x_in;
   logic signed [COORD_WIDTH-1:0] walk_y_ff, walk_y_in;
   logic [STEP_WIDTH-1:0]         steps_ff, steps_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_ff, rsp_in;

   logic                          in_map_ff, in_map;
   logic signed [PROD_WIDTH-1:0]  prod_a_ff, prod_b_ff, prod_c_ff, prod_d_ff;
   logic signed [PROD_WIDTH-1:0]  prod_a, prod_b, prod_c, prod_d;
   logic [SQ_WIDTH-1:0]           sq_x_ff, sq_y_ff, sq_x, sq_y;

   logic signed [REL_WIDTH-1:0]   rel_x, rel_y, rel_x_next, rel_y_next;
   logic signed [PROD_WIDTH-1:0]  dx_w, dy_w;
   logic signed [ERR_WIDTH-1:0]   err_x, err_y, err_x_neg, err_y_neg;
   logic [MAG_WIDTH-1:0]          mag_x, mag_y;
   logic [CMP_WIDTH-1:0]          len_cmp;
   logic                          near_x, near_y;
   logic                          at_target, cell_open, guard_hit;

   logic                          ram_wr_en;
   logic [MapAddrWidth-1:0]       ram_wr_addr;
   logic                          ram_wr_data;
   logic [MapAddrWidth-1:0]       ram_rd_addr;
   logic                          ram_rd_data;

   glosw_ram #(
      .WIDTH (1),
      .DEPTH (MapDepth)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // read address always follows the walker position
   assign ram_rd_addr = map_addr(walk_x_ff[7:0], walk_y_ff[7:0]);

   // look stage: cross products of both candidate cells
   always_comb begin
      rel_x      = REL_WIDTH'(walk_x_ff) - REL_WIDTH'(job_ff.origin_x);
      rel_y      = REL_WIDTH'(walk_y_ff) - REL_WIDTH'(job_ff.origin_y);
      rel_x_next = rel_x + (job_ff.step_x_neg ? RelMinus : RelOne);
      rel_y_next = rel_y + (job_ff.step_y_neg ? RelMinus : RelOne);
      dx_w       = PROD_WIDTH'(job_ff.delta_x);
      dy_w       = PROD_WIDTH'(job_ff.delta_y);
      prod_a     = dy_w * PROD_WIDTH'(rel_x_next);
      prod_b     = dx_w * PROD_WIDTH'(rel_y);
      prod_c     = dy_w * PROD_WIDTH'(rel_x);
      prod_d     = dx_w * PROD_WIDTH'(rel_y_next);
      in_map     = !walk_x_ff[COORD_WIDTH-1] && (walk_x_ff < MapLimit)
                && !walk_y_ff[COORD_WIDTH-1] && (walk_y_ff < MapLimit);
   end

   // square stage: magnitude of the line error, squared
   always_comb begin
      err_x     = ERR_WIDTH'(prod_a_ff) - ERR_WIDTH'(prod_b_ff);
      err_y     = ERR_WIDTH'(prod_c_ff) - ERR_WIDTH'(prod_d_ff);
      err_x_neg = -err_x;
      err_y_neg = -err_y;
      mag_x     = err_x[ERR_WIDTH-1] ? err_x_neg[MAG_WIDTH-1:0] : err_x[MAG_WIDTH-1:0];
      mag_y     = err_y[ERR_WIDTH-1] ? err_y_neg[MAG_WIDTH-1:0] : err_y[MAG_WIDTH-1:0];
      sq_x      = mag_x * mag_x;
      sq_y      = mag_y * mag_y;
   end

   // decide stage: 4*e*e against the squared line length
   always_comb begin
      len_cmp   = CMP_WIDTH'(job_ff.len_sq);
      near_x    = {sq_x_ff, 2'b00} < len_cmp;
      near_y    = {sq_y_ff, 2'b00} < len_cmp;
      cell_open = in_map_ff && ram_rd_data;
      guard_hit = (steps_ff == StepGuardVal);
      at_target = (walk_x_ff == COORD_WIDTH'(job_ff.target_x))
               && (walk_y_ff == COORD_WIDTH'(job_ff.target_y));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            if (clr_addr_ff == MapLastAddr) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!q_status.empty && (head_job.op == OP_CAST)) begin
               state_in = BK_LOOK;
            end
         end
         BK_LOOK: begin
            state_in = at_target ? BK_IDLE : BK_SQUARE;
         end
         BK_SQUARE: begin
            state_in = BK_DECIDE;
         end
         BK_DECIDE: begin
            state_in = (!cell_open || guard_hit) ? BK_IDLE : BK_LOOK;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      pop          = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = clr_addr_ff;
      ram_wr_data  = 1'b0;
      clr_addr_in  = clr_addr_ff;
      job_in       = job_ff;
      walk_x_in    = walk_x_ff;
      walk_y_in    = walk_y_ff;
      steps_in     = steps_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            ram_wr_en   = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         BK_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               if (head_job.op == OP_WRITE) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = map_addr({2'b00, head_job.cell_x}, {2'b00, head_job.cell_y});
                  ram_wr_data = head_job.walkable;
               end else begin
                  job_in    = head_job;
                  walk_x_in = COORD_WIDTH'(head_job.origin_x);
                  walk_y_in = COORD_WIDTH'(head_job.origin_y);
                  steps_in  = '0;
               end
            end
         end
         BK_LOOK: begin
            if (at_target) begin
               rsp_valid_in   = 1'b1;
               rsp_in.seen_x  = walk_x_ff[7:0];
               rsp_in.seen_y  = walk_y_ff[7:0];
               rsp_in.blocked = 1'b0;
            end
         end
         BK_SQUARE: begin
         end
         BK_DECIDE: begin
            if (!cell_open) begin
               rsp_valid_in   = 1'b1;
               rsp_in.seen_x  = walk_x_ff[7:0];
               rsp_in.seen_y  = walk_y_ff[7:0];
               rsp_in.blocked = 1'b1;
            end else if (guard_hit) begin
               rsp_valid_in   = 1'b1;
               rsp_in.seen_x  = job_ff.target_x;
               rsp_in.seen_y  = job_ff.target_y;
               rsp_in.blocked = 1'b0;
            end else begin
               steps_in = steps_ff + 1'b1;
               if (near_x) begin
                  walk_x_in = walk_x_ff + (job_ff.step_x_neg ? CoordMinus : CoordOne);
               end else if (near_y) begin
                  walk_y_in = walk_y_ff + (job_ff.step_y_neg ? CoordMinus : CoordOne);
               end else begin
                  walk_x_in = walk_x_ff + (job_ff.step_x_neg ? CoordMinus : CoordOne);
                  walk_y_in = walk_y_ff + (job_ff.step_y_neg ? CoordMinus : CoordOne);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         walk_x_ff    <= '0;
         walk_y_ff    <= '0;
         steps_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         walk_x_ff    <= walk_x_in;
         walk_y_ff    <= walk_y_in;
         steps_ff     <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      rsp_ff    <= rsp_in;
      in_map_ff <= in_map;
      prod_a_ff <= prod_a;
      prod_b_ff <= prod_b;
      prod_c_ff <= prod_c;
      prod_d_ff <= prod_d;
      sq_x_ff   <= sq_x;
      sq_y_ff   <= sq_y;
   end

   assign clearing  = (state_ff == BK_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// File: rtl/grid_line_of_sight_walker_unit.sv
// top level of the grid line-of-sight walker
// usage
//   request side: drive req_item and raise start; a beat is taken on the rising
//   edge where start is high and busy is low. cmd write stores one walkable bit
//   of the MAP_SIDE x MAP_SIDE tile map, cmd cast walks from origin to target
//   response side: one beat per cast, none per write; rsp_valid is high for one
//   cycle with rsp_item holding the blocker cell or the target. the receiver
//   cannot hold responses off, and none is ever needed to wait
//   walker loop: each cell of a cast passes in order through the map read
//   with cross products, the squaring of the line error and the step
//   decision. a cast that reaches its target answers from the map read step;
//   a cast stopped by a blocker answers from the step decision. a write is
//   done by the idle walker as it pops the job
//   throughput: one beat per cycle enters until the four-deep job queue is full;
//   beyond that the walker loop sets the pace
//   reset: the map is cleared by a pass over all MAP_SIDE*MAP_SIDE cells (4096 at
//   the default size), one cell per cycle; busy stays high until it ends
`timescale 1ns / 1ps

module grid_line_of_sight_walker_unit #(
   parameter int MAP_SIDE = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  glosw_pkg::req_type req_item,
   output logic               rsp_valid,
   output glosw_pkg::rsp_type rsp_item
);
   import glosw_pkg::*;

   // front end to queue
   logic         push;
   job_type      push_job;
   // queue to walker
   logic         pop;
   job_type      head_job;
   q_status_type q_status;
   // walker busy with the clearing pass
   logic         clearing;

   // accepts beats, drops writes off the map, precomputes line geometry
   glosw_front #(
      .MAP_SIDE (MAP_SIDE)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .clearing (clearing),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   // keeps writes and casts in arrival order
   glosw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // owns the map, runs the clearing pass and walks the casts
   glosw_back #(
      .MAP_SIDE (MAP_SIDE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_job  (head_job),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// File: rtl/glosw_checker.sv
// port-level checker for the line-of-sight walker, bound to the top level
`timescale 1ns / 1ps
`include "grid_line_of_sight_walker_unit_assert.svh"

module glosw_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input glosw_pkg::req_type req_item,
   input logic               rsp_valid
);
   import glosw_pkg::*;

   logic       cast_taken;
   logic [3:0] pend_ff, pend_in;

   assign cast_taken = start && !busy && (req_item.cmd == CMD_CAST);

   // casts taken but not yet answered
   always_comb begin
      case ({cast_taken, rsp_valid})
         2'b10:   pend_in = pend_ff + 1'b1;
         2'b01:   pend_in = pend_ff - 1'b1;
         default: pend_in = pend_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `GLOSW_ASSERT_NEXT(a_rsp_spaced, rsp_valid, !rsp_valid, "two response beats in a row")
   `GLOSW_ASSERT_HOLDS(a_rsp_has_cast, rsp_valid, pend_ff != 4'd0, "response without a cast")
   `GLOSW_ASSERT_HOLDS(a_clear_after_reset, $past(reset), busy, "not busy after reset")

endmodule

bind grid_line_of_sight_walker_unit glosw_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid)
);
